>>> hdl/encoder_period_capture_top_defines.svh
// assertion macros for the encoder period capture block
`ifndef ENCODER_PERIOD_CAPTURE_TOP_DEFINES_SVH
`define ENCODER_PERIOD_CAPTURE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ECAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ECAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ecap_pkg.sv
// types and constants shared by the encoder period capture files
`timescale 1ns / 1ps

package ecap_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int PERIOD_W   = 17;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd40000;

    typedef enum logic [0:0] {
        REG_PERIOD = 1'b0
    } t_reg_index;

    typedef enum logic [2:0] {
        ACT_OVERFLOW   = 3'd0,
        ACT_CAPTURE    = 3'd1,
        ACT_READ_IVL   = 3'd2,
        ACT_READ_STAMP = 3'd3,
        ACT_READ_LIVE  = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]  action;
        logic        channel;
        logic [15:0] capture_value;
        logic [15:0] counter_now;
    } t_in_item;

    typedef struct packed {
        logic        data_valid;
        logic [31:0] interval;
        logic [31:0] time_stamp;
        logic        rising_edge;
    } t_out_item;

endpackage

>>> hdl/ecap_if.sv
// valid/ready stream interfaces for input items and result items
`timescale 1ns / 1ps

interface ecap_in_if;
    import ecap_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ecap_out_if;
    import ecap_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/encoder_period_capture_top.sv
// encoder period capture top level: input-capture interval meter for encoder channels.
// One item is accepted every clock while results are taken; each result passes through the
// input register and then through the multiply-add stage into the result register. The
// input side keeps taking items while a finished result waits, until the input register
// is also full. period_ticks sits at byte address 0 of the APB port; the user must see
// that it is written only while the block is idle, as the block does not enforce this.
// There is no clearing pass after reset.
`timescale 1ns / 1ps
`include "encoder_period_capture_top_defines.svh"

module encoder_period_capture_top #(
    parameter int CHANNELS = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ecap_in_if.sink                        i_in,
    ecap_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ecap_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ecap_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ecap_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ecap_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [PERIOD_W-1:0] r_period;

    logic        r_in_vld;
    t_in_item    r_in;
    logic        r_out_vld;
    t_out_item   r_out;

    logic [31:0] r_ovf_since  [CHANNELS];
    logic [31:0] r_ovf_total  [CHANNELS];
    logic [15:0] r_prev_cap   [CHANNELS];
    logic [31:0] r_stored_ivl [CHANNELS];
    logic        r_fresh      [CHANNELS];
    logic [31:0] r_stamp      [CHANNELS];
    logic        r_edge_sel   [CHANNELS];

    logic            advance;
    logic            ch_ok;
    logic [CH_W-1:0] ch_idx;
    t_action         act;
    logic [31:0]     period_ext;
    logic [31:0]     ovf_ticks;
    logic [31:0]     live_time;
    logic [31:0]     ivl_new;
    logic            cur_edge;
    logic            is_ivl_source;
    t_out_item       n_out;

    // apb register port
    t_reg_index reg_index;
    assign reg_index = t_reg_index'(paddr[2]);
    assign pready    = 1'b1;

    always_comb begin
        case (reg_index)
            REG_PERIOD: prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, r_period};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (psel && penable && pwrite && pready && reg_index == REG_PERIOD) begin
            r_period <= pwdata[PERIOD_W-1:0];
        end
    end

    // stage control
    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // single-pass datapath
    assign act        = t_action'(r_in.action);
    assign ch_ok      = ({31'd0, r_in.channel} < 32'(CHANNELS));
    assign ch_idx     = CH_W'(r_in.channel);
    assign period_ext = {{(32-PERIOD_W){1'b0}}, r_period};
    assign ovf_ticks  = r_ovf_since[ch_idx] * period_ext;
    assign live_time  = r_ovf_total[0] * period_ext + {16'd0, r_in.counter_now};
    assign ivl_new    = {16'd0, r_in.capture_value} + ovf_ticks
                        - {16'd0, r_prev_cap[ch_idx]};
    assign cur_edge   = ch_ok ? r_edge_sel[ch_idx] : 1'b0;
    assign is_ivl_source = (act == ACT_CAPTURE) || (act == ACT_READ_IVL);

    always_comb begin
        n_out             = '0;
        n_out.rising_edge = cur_edge;
        case (act)
            ACT_READ_LIVE: begin
                n_out.time_stamp = live_time;
            end
            ACT_CAPTURE: begin
                if (ch_ok) begin
                    n_out.data_valid  = 1'b1;
                    n_out.interval    = ivl_new;
                    n_out.time_stamp  = live_time;
                    n_out.rising_edge = !cur_edge;
                end
            end
            ACT_READ_IVL: begin
                if (ch_ok && r_fresh[ch_idx]) begin
                    n_out.data_valid = 1'b1;
                    n_out.interval   = r_stored_ivl[ch_idx];
                end
            end
            ACT_READ_STAMP: begin
                if (ch_ok) begin
                    n_out.time_stamp = r_stamp[ch_idx];
                end
            end
            default: begin
                n_out.rising_edge = cur_edge;
            end
        endcase
    end

    // per-channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_ovf_since[i]  <= '0;
                r_ovf_total[i]  <= '0;
                r_prev_cap[i]   <= '0;
                r_stored_ivl[i] <= '0;
                r_fresh[i]      <= 1'b0;
                r_stamp[i]      <= '0;
                r_edge_sel[i]   <= 1'b0;
            end
        end else if (advance && ch_ok) begin
            case (act)
                ACT_OVERFLOW: begin
                    r_ovf_since[ch_idx] <= r_ovf_since[ch_idx] + 32'd1;
                    r_ovf_total[ch_idx] <= r_ovf_total[ch_idx] + 32'd1;
                end
                ACT_CAPTURE: begin
                    r_edge_sel[ch_idx]   <= !r_edge_sel[ch_idx];
                    r_ovf_since[ch_idx]  <= '0;
                    r_stamp[ch_idx]      <= live_time;
                    r_stored_ivl[ch_idx] <= ivl_new;
                    r_fresh[ch_idx]      <= 1'b1;
                    r_prev_cap[ch_idx]   <= r_in.capture_value;
                end
                ACT_READ_IVL: begin
                    r_fresh[ch_idx] <= 1'b0;
                end
                default: begin
                    r_fresh[ch_idx] <= r_fresh[ch_idx];
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    `ECAP_ASSERT_NEXT(a_capture_gives_valid, advance && ch_ok && act == ACT_CAPTURE, r_out_vld && r_out.data_valid, "capture did not give a valid result")
    `ECAP_ASSERT_NEXT(a_valid_source, advance, !r_out.data_valid || $past(is_ivl_source), "data_valid set by an action that gives no interval")
    `ECAP_ASSERT_NOW(a_hold_input, r_in_vld && !advance, !i_in.ready, "input register overwritten while held")
    `ECAP_ASSERT_NEXT(a_read_clears_fresh, advance && ch_ok && act == ACT_READ_IVL && r_fresh[ch_idx], r_out.data_valid && !r_fresh[$past(ch_idx)], "read interval did not clear the fresh flag")

endmodule

>>> verif/ecap_interval_checker.sv
// checker for the encoder period capture block: tracks period writes, predicts results, compares
`timescale 1ns / 1ps

module ecap_interval_checker #(
    parameter int CHANNELS = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ecap_in_if                              i_in,
    ecap_out_if                             i_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ecap_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ecap_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              o_fail_count,
    output int                              o_pending
);
    import ecap_pkg::*;

    localparam logic [APB_ADDR_W-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};

    logic [PERIOD_W-1:0] period_ticks;
    logic [31:0]         ovf_since     [CHANNELS];
    logic [31:0]         ovf_total     [CHANNELS];
    logic [15:0]         last_capture  [CHANNELS];
    logic [31:0]         held_interval [CHANNELS];
    logic                fresh         [CHANNELS];
    logic [31:0]         held_stamp    [CHANNELS];
    logic                edge_rising   [CHANNELS];
    t_out_item           results_due   [$];

    function automatic logic [31:0] live_time(logic [15:0] now);
        return ovf_total[0] * 32'(period_ticks) + 32'(now);
    endfunction

    function automatic t_out_item meter_response(t_in_item item);
        t_out_item   res;
        int unsigned ch;
        logic [31:0] ivl;
        res = '0;
        ch  = 32'(item.channel);
        if (item.action == ACT_READ_LIVE) begin
            res.time_stamp = live_time(item.counter_now);
            if (ch < CHANNELS) begin
                res.rising_edge = edge_rising[ch];
            end
        end else if (ch < CHANNELS) begin
            case (item.action)
                ACT_OVERFLOW: begin
                    ovf_since[ch] += 32'd1;
                    ovf_total[ch] += 32'd1;
                end
                ACT_CAPTURE: begin
                    edge_rising[ch] = ~edge_rising[ch];
                    ivl = 32'(item.capture_value) + ovf_since[ch] * 32'(period_ticks)
                          - 32'(last_capture[ch]);
                    ovf_since[ch]     = '0;
                    held_stamp[ch]    = live_time(item.counter_now);
                    held_interval[ch] = ivl;
                    fresh[ch]         = 1'b1;
                    last_capture[ch]  = item.capture_value;
                    res.data_valid    = 1'b1;
                    res.interval      = ivl;
                    res.time_stamp    = held_stamp[ch];
                end
                ACT_READ_IVL: begin
                    if (fresh[ch]) begin
                        res.interval   = held_interval[ch];
                        res.data_valid = 1'b1;
                        fresh[ch]      = 1'b0;
                    end
                end
                ACT_READ_STAMP: begin
                    res.time_stamp = held_stamp[ch];
                end
                default: begin
                end
            endcase
            res.rising_edge = edge_rising[ch];
        end
        return res;
    endfunction

    function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            period_ticks = PERIOD_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                ovf_since[c]     = '0;
                ovf_total[c]     = '0;
                last_capture[c]  = '0;
                held_interval[c] = '0;
                fresh[c]         = 1'b0;
                held_stamp[c]    = '0;
                edge_rising[c]   = 1'b0;
            end
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == PERIOD_ADDR) begin
                period_ticks = pwdata[PERIOD_W-1:0];
            end
            if (i_out.valid && i_out.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with nothing pending, expected none actual %0h",
                             $time, i_out.data);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    o_fail_count += field_mismatch("data_valid", 32'(want.data_valid),
                                                   32'(i_out.data.data_valid));
                    o_fail_count += field_mismatch("interval", want.interval,
                                                   i_out.data.interval);
                    o_fail_count += field_mismatch("time_stamp", want.time_stamp,
                                                   i_out.data.time_stamp);
                    o_fail_count += field_mismatch("rising_edge", 32'(want.rising_edge),
                                                   32'(i_out.data.rising_edge));
                end
            end
            if (i_in.valid && i_in.ready) begin
                results_due.push_back(meter_response(i_in.data));
            end
        end
        o_pending = results_due.size();
    end

endmodule

>>> verif/encoder_period_capture_top_tb.sv
// testbench top: drives encoder events, reads and period settings into the capture block
`timescale 1ns / 1ps

module encoder_period_capture_top_tb;
    import ecap_pkg::*;

    localparam int CHANNELS           = 2;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int RANDOM_PER_SETTING = 110;
    localparam int BURST_TICKS        = 24;
    localparam int MAX_WAIT           = 6;

    localparam logic [2:0] ACT_RESERVED_LO  = 3'd5;
    localparam logic [2:0] ACT_RESERVED_MID = 3'd6;
    localparam logic [2:0] ACT_RESERVED_HI  = 3'd7;

    localparam logic [APB_ADDR_W-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};
    localparam logic [PERIOD_W-1:0]   PERIOD_MAX  = '1;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int cycles     = 0;
    int items_sent = 0;
    bit quiet      = 1'b0;

    ecap_in_if  in_bus ();
    ecap_out_if out_bus ();

    encoder_period_capture_top #(
        .CHANNELS(CHANNELS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ecap_interval_checker #(
        .CHANNELS(CHANNELS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_bus),
        .i_out        (out_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic [2:0] action, logic channel,
                                           logic [15:0] cap, logic [15:0] now);
        t_in_item item;
        item.action        = action;
        item.channel       = channel;
        item.capture_value = cap;
        item.counter_now   = now;
        return item;
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= item;
        @(posedge i_clk);
        while (!(in_bus.valid && in_bus.ready)) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        out_bus.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_bus.valid && out_bus.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [PERIOD_W-1:0] settings [5];
        t_in_item            item;
        int unsigned         pick;

        in_bus.valid = 1'b0;
        in_bus.data  = '0;
        settings = '{17'd1, 17'd0, 17'd65536, PERIOD_MAX, 17'($urandom_range(2, 65535))};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset period, fresh-flag handling, reserved codes and interval wrap
        send_item(make_item(ACT_READ_IVL, 1'b0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_READ_STAMP, 1'b1, 16'hffff, 16'h0000));
        send_item(make_item(ACT_READ_LIVE, 1'b0, 16'h0000, 16'hffff));
        send_item(make_item(ACT_RESERVED_LO, 1'b0, 16'h1234, 16'h4321));
        send_item(make_item(ACT_RESERVED_MID, 1'b1, 16'h0000, 16'h0000));
        send_item(make_item(ACT_RESERVED_HI, 1'b0, 16'hffff, 16'hffff));
        send_item(make_item(ACT_OVERFLOW, 1'b0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_OVERFLOW, 1'b0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_OVERFLOW, 1'b1, 16'h0000, 16'h0000));
        send_item(make_item(ACT_CAPTURE, 1'b0, 16'hffff, 16'hffff));
        send_item(make_item(ACT_CAPTURE, 1'b1, 16'h0000, 16'h0000));
        send_item(make_item(ACT_CAPTURE, 1'b1, 16'h0000, 16'h1234));
        send_item(make_item(ACT_CAPTURE, 1'b0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_READ_IVL, 1'b0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_READ_IVL, 1'b0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_READ_IVL, 1'b1, 16'h0000, 16'h0000));
        send_item(make_item(ACT_READ_STAMP, 1'b0, 16'h0000, 16'h0000));
        send_item(make_item(ACT_READ_STAMP, 1'b1, 16'h0000, 16'h0000));
        send_item(make_item(ACT_READ_LIVE, 1'b1, 16'hffff, 16'h8000));
        send_item(make_item(ACT_OVERFLOW, 1'b1, 16'hffff, 16'hffff));
        send_item(make_item(ACT_CAPTURE, 1'b1, 16'h8000, 16'h7fff));
        send_item(make_item(ACT_RESERVED_HI, 1'b1, 16'h5555, 16'haaaa));

        foreach (settings[s]) begin
            wait_idle();
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= PERIOD_ADDR;
            pwdata  <= APB_DATA_W'(settings[s]);
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;

            // back-to-back overflow run on timer 0 at the largest period
            if (settings[s] == PERIOD_MAX) begin
                quiet = 1'b1;
                repeat (BURST_TICKS) begin
                    send_item(make_item(ACT_OVERFLOW, 1'b0, 16'($urandom), 16'($urandom)));
                end
                quiet = 1'b0;
            end

            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
                if (n % 40 == 0) begin
                    quiet = ($urandom_range(0, 3) == 0);
                end
                if (s == 2 && n == RANDOM_PER_SETTING / 2) begin
                    wait_idle();
                end
                pick = $urandom_range(0, 99);
                item.channel       = 1'($urandom_range(0, 1));
                item.capture_value = 16'($urandom);
                item.counter_now   = 16'($urandom);
                if (pick < 30) begin
                    item.action = ACT_OVERFLOW;
                end else if (pick < 55) begin
                    item.action = ACT_CAPTURE;
                end else if (pick < 70) begin
                    item.action = ACT_READ_IVL;
                end else if (pick < 80) begin
                    item.action = ACT_READ_STAMP;
                end else if (pick < 90) begin
                    item.action = ACT_READ_LIVE;
                end else begin
                    item.action = 3'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI));
                end
                send_item(item);
            end
        end

        quiet = 1'b0;
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d items: all action codes on both channels, fresh-flag reads,",
                 items_sent);
        $display("period 40000, 1, 0, 65536, %0d and %0d, and a %0d-tick overflow run",
                 PERIOD_MAX, settings[4], BURST_TICKS);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ecap_pkg.sv
hdl/ecap_if.sv
hdl/encoder_period_capture_top.sv
verif/ecap_interval_checker.sv
verif/encoder_period_capture_top_tb.sv
